>>> rtl/core/gbmc_pkg.sv
// Package for the graded box mesh coordinate core.
// Request/result payload types, config bundle, inter-stage types and shared constants.
// No dependencies.
package gbmc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;

  localparam logic [CfgIdxW-1:0] CFG_GRID_SIZE    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRID_SPACING = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_INNER_RADIUS = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_OUTER_GAIN   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SPAN_RECIP   = 3'd4;

  localparam logic [23:0] ONE_Q16 = 24'd65536;

  // gain clamp: never below 1.0; anything above 2^48 saturates every non-zero coordinate
  localparam int MulW = 49;
  localparam logic [MulW-1:0] MUL_MIN = 49'h0_0000_0001_0000;
  localparam logic [MulW-1:0] MUL_SAT = 49'h1_0000_0000_0001;

  localparam logic [8:0]  RST_GRID_SIZE    = 9'd64;
  localparam logic [23:0] RST_GRID_SPACING = 24'd65536;
  localparam logic [30:0] RST_INNER_RADIUS = 31'd0;
  localparam logic [23:0] RST_OUTER_GAIN   = 24'd65536;
  localparam logic [30:0] RST_SPAN_RECIP   = 31'd65536;

  typedef struct packed {
    logic [7:0] node_x;
    logic [7:0] node_y;
    logic [7:0] node_z;
  } node_req_t;

  typedef struct packed {
    logic [23:0]        node_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } node_res_t;

  typedef struct packed {
    logic [8:0]  grid_size;
    logic [23:0] grid_spacing;
    logic [30:0] inner_radius;
    logic [23:0] outer_gain;
    logic [30:0] span_reciprocal;
  } cfg_t;

  // per-node data carried alongside the gain computation
  typedef struct packed {
    logic [23:0] node_index;
    logic [32:0] mag_x;
    logic [32:0] mag_y;
    logic [32:0] mag_z;
    logic        neg_x;
    logic        neg_y;
    logic        neg_z;
  } side_t;

endpackage

>>> rtl/core/graded_box_mesh_coordinates_core.sv
// Top level of the graded box mesh coordinate core.
// Config registers, request pipeline, three coordinate lanes. Depends on gbmc_pkg,
// gbmc_front, gbmc_gain and gbmc_scale.

// Takes one grid node per clock cycle and returns its linear index and graded position
// after the front end (3), gain path (4) and scaling (3) register stages; a new request
// may follow every cycle. busy is high only during reset.
// done marks each result for a single cycle and cannot be held off, so the receiver must
// take every result as it appears. Config writes take effect at once and are to be made
// only when no request is in flight.
module graded_box_mesh_coordinates_core #(
  parameter int GRID_MAX = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  gbmc_pkg::node_req_t                 in_req,
  output logic                                done,
  output gbmc_pkg::node_res_t                 result,
  input  logic                                cfg_wr_en,
  input  logic [gbmc_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [gbmc_pkg::CfgDataW-1:0]       cfg_data
);

  localparam int ScaleLat = 3;

  gbmc_pkg::cfg_t  cfg;
  logic            accept;

  logic            fr_valid;
  gbmc_pkg::side_t fr_side;
  logic signed [32:0] fr_dist;

  logic            gn_valid;
  gbmc_pkg::side_t gn_side;
  logic [gbmc_pkg::MulW-1:0] gn_mul;

  logic [ScaleLat-1:0] valid;
  logic [23:0]         idx [ScaleLat];

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_size       <= gbmc_pkg::RST_GRID_SIZE;
      cfg.grid_spacing    <= gbmc_pkg::RST_GRID_SPACING;
      cfg.inner_radius    <= gbmc_pkg::RST_INNER_RADIUS;
      cfg.outer_gain      <= gbmc_pkg::RST_OUTER_GAIN;
      cfg.span_reciprocal <= gbmc_pkg::RST_SPAN_RECIP;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gbmc_pkg::CFG_GRID_SIZE:    cfg.grid_size       <= cfg_data[8:0];
        gbmc_pkg::CFG_GRID_SPACING: cfg.grid_spacing    <= cfg_data[23:0];
        gbmc_pkg::CFG_INNER_RADIUS: cfg.inner_radius    <= cfg_data[30:0];
        gbmc_pkg::CFG_OUTER_GAIN:   cfg.outer_gain      <= cfg_data[23:0];
        gbmc_pkg::CFG_SPAN_RECIP:   cfg.span_reciprocal <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  gbmc_front #(
    .GRID_MAX(GRID_MAX)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .in_req   (in_req),
    .cfg      (cfg),
    .out_valid(fr_valid),
    .out_side (fr_side),
    .out_dist (fr_dist)
  );

  gbmc_gain u_gain (
    .clk      (clk),
    .rst      (rst),
    .in_valid (fr_valid),
    .in_side  (fr_side),
    .in_dist  (fr_dist),
    .cfg      (cfg),
    .out_valid(gn_valid),
    .out_side (gn_side),
    .out_mul  (gn_mul)
  );

  gbmc_scale u_scale_x (
    .clk(clk),
    .mag(gn_side.mag_x),
    .neg(gn_side.neg_x),
    .mul(gn_mul),
    .pos(result.pos_x)
  );

  gbmc_scale u_scale_y (
    .clk(clk),
    .mag(gn_side.mag_y),
    .neg(gn_side.neg_y),
    .mul(gn_mul),
    .pos(result.pos_y)
  );

  gbmc_scale u_scale_z (
    .clk(clk),
    .mag(gn_side.mag_z),
    .neg(gn_side.neg_z),
    .mul(gn_mul),
    .pos(result.pos_z)
  );

  always_ff @(posedge clk) begin
    idx[0] <= gn_side.node_index;
    for (int i = 1; i < ScaleLat; i++) begin
      idx[i] <= idx[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[ScaleLat-2:0], gn_valid};
    end
  end

  assign result.node_index = idx[ScaleLat-1];
  assign done              = valid[ScaleLat-1];

`ifndef SYNTHESIS
  a_done_from_request : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 10))
    else $error("result strobe without a request ten cycles earlier");
`endif

endmodule

>>> rtl/core/gbmc_front.sv
// Front end: grid-size clamp, centring, linear index and Chebyshev distance.
// Three register stages. Depends on gbmc_pkg.
module gbmc_front #(
  parameter int GRID_MAX = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  gbmc_pkg::node_req_t in_req,
  input  gbmc_pkg::cfg_t      cfg,
  output logic                out_valid,
  output gbmc_pkg::side_t     out_side,
  output logic signed [32:0]  out_dist
);

  logic [8:0]         n_clamp;
  logic signed [10:0] c_x_next, c_y_next, c_z_next;

  logic [2:0]         valid;
  logic signed [10:0] c_x, c_y, c_z;
  logic [7:0]         x1, z1;
  logic [16:0]        ny1;
  logic [17:0]        nn1;

  logic signed [35:0] px, py, pz;
  logic [25:0]        idx_full;
  logic signed [33:0] x2, y2, z2;
  logic [23:0]        idx2;

  logic signed [33:0] nx2, ny2, nz2;
  logic [32:0]        mx, my, mz, fmax;
  logic signed [32:0] dist_next;

  always_comb begin
    if (cfg.grid_size < 9'd2) begin
      n_clamp = 9'd2;
    end else if (32'(cfg.grid_size) > GRID_MAX) begin
      n_clamp = 9'(GRID_MAX);
    end else begin
      n_clamp = cfg.grid_size;
    end
    c_x_next = $signed({2'b00, in_req.node_x, 1'b1}) - $signed({2'b00, n_clamp});
    c_y_next = $signed({2'b00, in_req.node_y, 1'b1}) - $signed({2'b00, n_clamp});
    c_z_next = $signed({2'b00, in_req.node_z, 1'b1}) - $signed({2'b00, n_clamp});
  end

  always_ff @(posedge clk) begin
    c_x <= c_x_next;
    c_y <= c_y_next;
    c_z <= c_z_next;
    x1  <= in_req.node_x;
    z1  <= in_req.node_z;
    ny1 <= n_clamp * in_req.node_y;
    nn1 <= n_clamp * n_clamp;
  end

  // stage 2: centred coordinates in units of 2^-17, index
  always_comb begin
    px = c_x * $signed({1'b0, cfg.grid_spacing});
    py = c_y * $signed({1'b0, cfg.grid_spacing});
    pz = c_z * $signed({1'b0, cfg.grid_spacing});
    idx_full = {18'd0, x1} + {9'd0, ny1} + ({8'd0, nn1} * {18'd0, z1});
  end

  always_ff @(posedge clk) begin
    x2   <= px[33:0];
    y2   <= py[33:0];
    z2   <= pz[33:0];
    idx2 <= idx_full[23:0];
  end

  // stage 3: magnitudes, Chebyshev distance less inner radius
  always_comb begin
    nx2 = -x2;
    ny2 = -y2;
    nz2 = -z2;
    mx = x2[33] ? nx2[32:0] : x2[32:0];
    my = y2[33] ? ny2[32:0] : y2[32:0];
    mz = z2[33] ? nz2[32:0] : z2[32:0];
    fmax = mx;
    if (my > fmax) begin
      fmax = my;
    end
    if (mz > fmax) begin
      fmax = mz;
    end
    dist_next = $signed({1'b0, fmax[32:1]}) - $signed({2'b00, cfg.inner_radius});
  end

  always_ff @(posedge clk) begin
    out_side.node_index <= idx2;
    out_side.mag_x      <= mx;
    out_side.mag_y      <= my;
    out_side.mag_z      <= mz;
    out_side.neg_x      <= x2[33];
    out_side.neg_y      <= y2[33];
    out_side.neg_z      <= z2[33];
    out_dist            <= dist_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[1:0], in_valid};
    end
  end

  assign out_valid = valid[2];

endmodule

>>> rtl/core/gbmc_gain.sv
// Gain path: ratio from distance, graded multiplier with floor clamp and saturation cap.
// Four register stages; node side data delayed to match. Depends on gbmc_pkg.
module gbmc_gain (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  gbmc_pkg::side_t                in_side,
  input  logic signed [32:0]             in_dist,
  input  gbmc_pkg::cfg_t                 cfg,
  output logic                           out_valid,
  output gbmc_pkg::side_t                out_side,
  output logic [gbmc_pkg::MulW-1:0]      out_mul
);

  localparam int Lat = 4;

  logic signed [64:0] prod_full;
  logic signed [63:0] p4;
  logic signed [48:0] a_next, a5;
  logic signed [32:0] ah;
  logic signed [16:0] al;
  logic signed [24:0] g;
  logic signed [57:0] ph;
  logic signed [41:0] pl;
  logic signed [58:0] m_full;
  logic [gbmc_pkg::MulW-1:0] mul_next;

  logic [Lat-1:0]  valid;
  gbmc_pkg::side_t side [Lat];

  assign prod_full = in_dist * $signed({1'b0, cfg.span_reciprocal});

  always_ff @(posedge clk) begin
    p4 <= prod_full[63:0];
  end

  assign a_next = $signed({p4[63], p4[63:16]}) + 49'sd65536;

  always_ff @(posedge clk) begin
    a5 <= a_next;
  end

  // split a into integer and fraction so each product stays narrow
  always_comb begin
    ah = $signed(a5[48:16]);
    al = $signed({1'b0, a5[15:0]});
    g  = $signed({1'b0, cfg.outer_gain}) - $signed({1'b0, gbmc_pkg::ONE_Q16});
  end

  always_ff @(posedge clk) begin
    ph <= ah * g;
    pl <= al * g;
  end

  always_comb begin
    m_full = $signed({ph[57], ph}) + $signed({{33{pl[41]}}, pl[41:16]}) + 59'sd65536;
    if (m_full < $signed({10'd0, gbmc_pkg::MUL_MIN})) begin
      mul_next = gbmc_pkg::MUL_MIN;
    end else if (m_full > $signed({10'd0, gbmc_pkg::MUL_SAT})) begin
      mul_next = gbmc_pkg::MUL_SAT;
    end else begin
      mul_next = m_full[gbmc_pkg::MulW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    out_mul <= mul_next;
  end

  always_ff @(posedge clk) begin
    side[0] <= in_side;
    for (int i = 1; i < Lat; i++) begin
      side[i] <= side[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[Lat-2:0], in_valid};
    end
  end

  assign out_valid = valid[Lat-1];
  assign out_side  = side[Lat-1];

`ifndef SYNTHESIS
  a_valid_follows : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, Lat))
    else $error("gain stage valid without matching request");

  a_mul_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_mul >= gbmc_pkg::MUL_MIN && out_mul <= gbmc_pkg::MUL_SAT))
    else $error("gain outside clamp range");
`endif

endmodule

>>> rtl/core/gbmc_scale.sv
// One coordinate lane: magnitude times gain, rounding towards minus infinity, 32-bit saturation.
// Three register stages. Depends on gbmc_pkg.
module gbmc_scale (
  input  logic                      clk,
  input  logic [32:0]               mag,
  input  logic                      neg,
  input  logic [gbmc_pkg::MulW-1:0] mul,
  output logic signed [31:0]        pos
);

  logic [56:0] hi;
  logic [57:0] lo;
  logic        neg8, neg9;
  logic [81:0] prod;
  logic [49:0] rnd;
  logic [31:0] q;
  logic        sat_p, sat_n;
  logic signed [31:0] pos_next;

  always_ff @(posedge clk) begin
    hi   <= mag * mul[48:25];
    lo   <= mag * mul[24:0];
    neg8 <= neg;
  end

  always_ff @(posedge clk) begin
    prod <= {hi, 25'd0} + {24'd0, lo};
    neg9 <= neg8;
  end

  always_comb begin
    rnd   = {1'b0, prod[48:0]} + 50'h1FFFF;
    q     = rnd[48:17];
    sat_p = prod[81:48] != '0;
    sat_n = (prod[81:49] != '0) || (prod[48] && (prod[47:0] != '0));
    if (neg9) begin
      pos_next = sat_n ? 32'sh8000_0000 : $signed(-q);
    end else begin
      pos_next = sat_p ? 32'sh7FFF_FFFF : $signed({1'b0, prod[47:17]});
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
  end

`ifndef SYNTHESIS
  a_zero_stays_zero : assert property (@(posedge clk)
    (mag == '0) |=> ##2 (pos == '0))
    else $error("zero coordinate scaled to non-zero");
`endif

endmodule
